FILE: rtl/ccc_pkg.sv
// types, codes and helper functions for the two-pass color combiner
`default_nettype none

package ccc_pkg;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_PRIM_COLOR   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_ENV_COLOR    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_TWO_CYCLE    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_FIRST_CUSTOM = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_FIRST_SEL    = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_SECOND_CUST  = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_SECOND_SEL   = 3'd6;

  // source ids
  localparam logic [2:0] SRC_COMBINED = 3'd0;
  localparam logic [2:0] SRC_TEXEL0   = 3'd1;
  localparam logic [2:0] SRC_TEXEL1   = 3'd2;
  localparam logic [2:0] SRC_SHADE    = 3'd3;
  localparam logic [2:0] SRC_PRIM     = 3'd4;
  localparam logic [2:0] SRC_ENV      = 3'd5;
  localparam logic [2:0] SRC_ONE      = 3'd6;
  localparam logic [2:0] SRC_ZERO     = 3'd7;

  // modulate preset: A texel0, B zero, C shade, D zero
  localparam logic [11:0] ModulateSel = {SRC_ZERO, SRC_SHADE, SRC_ZERO, SRC_TEXEL0};

  localparam logic [7:0]  ChanMax  = 8'd255;
  localparam logic [18:0] RoundAdd = 19'h00080;

  // channel 0 red, 1 green, 2 blue
  typedef logic [2:0][7:0] rgb8_t;

  typedef struct packed {
    rgb8_t t0;
    rgb8_t t1;
    rgb8_t sh;
    rgb8_t comb;
    logic  two_cycle;
  } pix_t;

  typedef struct packed {
    logic        custom;
    logic [11:0] selects;
  } pass_cfg_t;

  function automatic rgb8_t widen(logic [15:0] c);
    rgb8_t o;
    o[0] = {c[15:11], c[15:13]};
    o[1] = {c[10:5], c[10:9]};
    o[2] = {c[4:0], c[4:2]};
    return o;
  endfunction

  function automatic rgb8_t pick(logic [2:0] id, rgb8_t t0, rgb8_t t1, rgb8_t sh,
                                 rgb8_t comb, rgb8_t prim, rgb8_t env);
    rgb8_t o;
    unique case (id)
      SRC_COMBINED: o = comb;
      SRC_TEXEL0:   o = t0;
      SRC_TEXEL1:   o = t1;
      SRC_SHADE:    o = sh;
      SRC_PRIM:     o = prim;
      SRC_ENV:      o = env;
      SRC_ONE:      o = {3{ChanMax}};
      default:      o = '0;
    endcase
    return o;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/ccc_intf.sv
// channel interfaces: pixel input, pixel output and register write
`default_nettype none

interface ccc_pix_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] texel0_color;
  logic [15:0] texel1_color;
  logic [15:0] shade_color;

  modport source(output valid, texel0_color, texel1_color, shade_color, input ready);
  modport sink(input valid, texel0_color, texel1_color, shade_color, output ready);
endinterface

interface ccc_pix_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] out_color;
  logic        keep_pixel;

  modport source(output valid, out_color, keep_pixel, input ready);
  modport sink(input valid, out_color, keep_pixel, output ready);
endinterface

interface ccc_cfg_if;
  import ccc_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/ccc_pass.sv
// one combiner pass: source select, multiply, round and clamp in three stages
`default_nettype none

module ccc_pass (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire ccc_pkg::pass_cfg_t cfg_i,
  input  wire ccc_pkg::rgb8_t    prim_i,
  input  wire ccc_pkg::rgb8_t    env_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire ccc_pkg::pix_t     in_pix_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output ccc_pkg::pix_t          out_pix_o,
  output ccc_pkg::rgb8_t         out_res_o
);
  import ccc_pkg::*;

  logic        en1, en2, en3;
  logic [11:0] sel;
  rgb8_t       a_d, b_d, c_d, d_d;

  logic  v1_q, v2_q, v3_q;
  rgb8_t a_q, b_q, c_q, d_q;
  pix_t  pix1_q, pix2_q, pix3_q;

  logic signed [17:0] prod_d [3];
  logic signed [17:0] prod_q [3];
  rgb8_t              d2_q;

  rgb8_t res_d, res_q;

  assign en3 = !v3_q || out_ready_i;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_ready_o = en1;

  assign sel = cfg_i.custom ? cfg_i.selects : ModulateSel;

  always_comb begin
    a_d = pick(sel[2:0],  in_pix_i.t0, in_pix_i.t1, in_pix_i.sh, in_pix_i.comb, prim_i, env_i);
    b_d = pick(sel[5:3],  in_pix_i.t0, in_pix_i.t1, in_pix_i.sh, in_pix_i.comb, prim_i, env_i);
    c_d = pick(sel[8:6],  in_pix_i.t0, in_pix_i.t1, in_pix_i.sh, in_pix_i.comb, prim_i, env_i);
    d_d = pick(sel[11:9], in_pix_i.t0, in_pix_i.t1, in_pix_i.sh, in_pix_i.comb, prim_i, env_i);
  end

  always_comb begin
    logic signed [8:0] diff;
    logic signed [8:0] cs;
    for (int k = 0; k < 3; k++) begin
      diff = $signed({1'b0, a_q[k]}) - $signed({1'b0, b_q[k]});
      cs = $signed({1'b0, c_q[k]});
      prod_d[k] = 18'(diff) * 18'(cs);
    end
  end

  // sum is below 2^17 when positive, so bits 17:16 flag overflow past 255
  always_comb begin
    logic signed [18:0] sum;
    for (int k = 0; k < 3; k++) begin
      sum = 19'(prod_q[k]) + $signed({3'b000, d2_q[k], 8'h00}) + $signed(RoundAdd);
      if (sum[18]) begin
        res_d[k] = '0;
      end else if (sum[17:16] != 2'b00) begin
        res_d[k] = ChanMax;
      end else begin
        res_d[k] = sum[15:8];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && in_valid_i) begin
      a_q    <= a_d;
      b_q    <= b_d;
      c_q    <= c_d;
      d_q    <= d_d;
      pix1_q <= in_pix_i;
    end
    if (en2 && v1_q) begin
      for (int k = 0; k < 3; k++) prod_q[k] <= prod_d[k];
      d2_q   <= d_q;
      pix2_q <= pix1_q;
    end
    if (en3 && v2_q) begin
      res_q  <= res_d;
      pix3_q <= pix2_q;
    end
  end

  assign out_valid_o = v3_q;
  assign out_pix_o   = pix3_q;
  assign out_res_o   = res_q;

endmodule

`default_nettype wire

FILE: rtl/two_cycle_color_combiner.sv
// top level: register file, two chained combiner passes, RGB565 pack
//
//  channel  dir  payload                                         transfer when
//  in_i     in   texel0_color, texel1_color, shade_color         valid & ready
//  out_o    out  out_color, keep_pixel                           valid & ready
//  cfg_i    in   index (3 bits), data (16 bits)                  valid & ready
//
// six register stages, three per pass; one pixel can enter every cycle while
// out_o is not stalled. single-pass mode runs through both passes too and
// the second pass result is dropped at the output in favor of the first.
// reset clears all valid bits and the config registers to 0. ready is taken back only
// by a full stage whose successor is stalled, so nothing is lost or repeated.
// cfg_i is always ready; registers may only change while the pipe is empty.
`default_nettype none

module two_cycle_color_combiner (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  ccc_pix_in_if.sink   in_i,
  ccc_pix_out_if.source out_o,
  ccc_cfg_if.sink      cfg_i
);
  import ccc_pkg::*;

  logic [15:0] prim_q, env_q;
  logic        two_cycle_q, first_custom_q, second_custom_q;
  logic [11:0] first_sel_q, second_sel_q;

  rgb8_t     prim8, env8;
  pass_cfg_t cfg1, cfg2;
  pix_t      pix_in, p1_pix, p2_in, p2_pix;
  rgb8_t     p1_res, p2_res, fin;
  logic      p1_valid, p1_ready, p2_valid;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prim_q          <= '0;
      env_q           <= '0;
      two_cycle_q     <= 1'b0;
      first_custom_q  <= 1'b0;
      first_sel_q     <= '0;
      second_custom_q <= 1'b0;
      second_sel_q    <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_PRIM_COLOR:   prim_q          <= cfg_i.data;
        REG_ENV_COLOR:    env_q           <= cfg_i.data;
        REG_TWO_CYCLE:    two_cycle_q     <= cfg_i.data[0];
        REG_FIRST_CUSTOM: first_custom_q  <= cfg_i.data[0];
        REG_FIRST_SEL:    first_sel_q     <= cfg_i.data[11:0];
        REG_SECOND_CUST:  second_custom_q <= cfg_i.data[0];
        REG_SECOND_SEL:   second_sel_q    <= cfg_i.data[11:0];
        default: ;
      endcase
    end
  end

  assign prim8 = widen(prim_q);
  assign env8  = widen(env_q);
  assign cfg1  = '{custom: first_custom_q, selects: first_sel_q};
  assign cfg2  = '{custom: second_custom_q, selects: second_sel_q};

  // texel1 reads zero in single-pass mode, combined is zero in the first pass
  always_comb begin
    pix_in.t0        = widen(in_i.texel0_color);
    pix_in.t1        = two_cycle_q ? widen(in_i.texel1_color) : '0;
    pix_in.sh        = widen(in_i.shade_color);
    pix_in.comb      = '0;
    pix_in.two_cycle = two_cycle_q;
  end

  ccc_pass u_pass1 (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg1),
    .prim_i      (prim8),
    .env_i       (env8),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .in_pix_i    (pix_in),
    .out_valid_o (p1_valid),
    .out_ready_i (p1_ready),
    .out_pix_o   (p1_pix),
    .out_res_o   (p1_res)
  );

  always_comb begin
    p2_in      = p1_pix;
    p2_in.comb = p1_res;
  end

  ccc_pass u_pass2 (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg2),
    .prim_i      (prim8),
    .env_i       (env8),
    .in_valid_i  (p1_valid),
    .in_ready_o  (p1_ready),
    .in_pix_i    (p2_in),
    .out_valid_o (p2_valid),
    .out_ready_i (out_o.ready),
    .out_pix_o   (p2_pix),
    .out_res_o   (p2_res)
  );

  // comb still holds the first pass result at the end of the second pass
  assign fin = p2_pix.two_cycle ? p2_res : p2_pix.comb;

  assign out_o.valid      = p2_valid;
  assign out_o.out_color  = {fin[0][7:3], fin[1][7:2], fin[2][7:3]};
  assign out_o.keep_pixel = 1'b1;

endmodule

`default_nettype wire

FILE: rtl/ccc_checker.sv
// port-level checker for the combiner and its bind to the top level
`default_nettype none

module ccc_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [15:0] out_color_i,
  input wire logic        keep_pixel_i
);

  localparam logic [2:0] PipeDepth = 3'd6;

  logic [2:0] cnt_q, cnt_d;
  logic       in_xfer, out_xfer;

  assign in_xfer  = in_valid_i && in_ready_i;
  assign out_xfer = out_valid_i && out_ready_i;

  always_comb begin
    cnt_d = cnt_q;
    if (in_xfer && !out_xfer) cnt_d = cnt_q + 3'd1;
    else if (!in_xfer && out_xfer) cnt_d = cnt_q - 3'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // no result without a pixel in flight
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> cnt_q != 3'd0)
    else $error("result without a pending pixel");

  // never more pixels in flight than pipeline stages
  a_occupancy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= PipeDepth)
    else $error("more pixels in flight than stages");

  a_keep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> keep_pixel_i)
    else $error("keep flag low on a result");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_color_i))
    else $error("stalled result changed or dropped");

endmodule

bind two_cycle_color_combiner ccc_checker u_ccc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_color_i  (out_o.out_color),
  .keep_pixel_i (out_o.keep_pixel)
);

`default_nettype wire
